[rtl/spct_pkg.sv]
package spct_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_POLYGONS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MASK_BITS        = 16;
    localparam int TYPE_BITS        = 2;

    localparam logic [TYPE_BITS-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [TYPE_BITS-1:0] REQ_APPEND = 2'd1;
    localparam logic [TYPE_BITS-1:0] REQ_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // edge control flags: valid, first, last, done
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic done;
    } edge_ctl_t;

    function automatic logic pair_passes(input logic [1:0] s1, input logic [1:0] s2);
        // sign code: bit1 negative, bit0 nonzero
        logic z1;
        logic z2;
        z1 = !s1[0];
        z2 = !s2[0];
        return (z1 && z2) || (s1[0] && s2[0] && (s1[1] != s2[1]));
    endfunction

endpackage

[rtl/spct_if.sv]
interface spct_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/spct_ram.sv]
module spct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/spct_cell.sv]
// One cross product sign per cell, with the products split over two stages.
module spct_cell #(
    parameter int CB = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic signed [CB:0]  in_px,
    input  logic signed [CB:0]  in_qy,
    input  logic signed [CB:0]  in_py,
    input  logic signed [CB:0]  in_qx,
    output logic                out_vld,
    output logic [1:0]          out_sign
);
    logic signed [2*CB+1:0] m1_reg;
    logic signed [2*CB+1:0] m2_reg;
    logic                   v_reg;
    logic signed [2*CB+2:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            out_vld <= 1'b0;
        end
        else
        begin
            v_reg   <= in_vld;
            out_vld <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg   <= in_px * in_qy;
        m2_reg   <= in_py * in_qx;
        out_sign <= {diff[2*CB+2], |diff};
    end

    assign diff = {m1_reg[2*CB+1], m1_reg} - {m2_reg[2*CB+1], m2_reg};
endmodule

[rtl/segment_polygon_cross_test_unit.sv]
// Segment versus polygon crossing test.
// Input channel 'req' carries {req_type, ax, ay, bx, by, closes_polygon};
// output channel 'rsp' carries {crossed, crossed_mask, store_overflow}.
// Clear and append words give no result.
// Append beyond MAX_VERTICES vertices or MAX_POLYGONS polygons is dropped
// and sets the sticky overflow flag; clear resets it.
// A query streams the stored vertices out of the RAM one per cycle into a
// row of four cross-product cells (two stages each); the result word is
// registered as the FSM leaves state OUT, after states READ and DRAIN
// (READ is skipped with an empty store).
// Only one query is in work at a time; the result word sits in the output
// register until taken, and no new word is accepted while it waits. The
// next word can be taken in the cycle after the result word is taken.
// Reset clears counts and flags; the vertex RAM is not cleared, entries
// beyond the count are never read.
module segment_polygon_cross_test_unit #(
    parameter int MAX_VERTICES = spct_pkg::MAX_VERTICES_DEF,
    parameter int MAX_POLYGONS = spct_pkg::MAX_POLYGONS_DEF,
    parameter int COORD_BITS   = spct_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    spct_if.sink   req,
    spct_if.source rsp
);
    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int PW = $clog2(MAX_POLYGONS + 1);
    localparam int MB = spct_pkg::MASK_BITS;
    localparam int TB = spct_pkg::TYPE_BITS;
    localparam int RW = 2 * CB + 1;
    localparam int XW = (PW > $clog2(MB) + 1) ? PW : $clog2(MB) + 1;

    logic [TB-1:0]        rtype;
    logic signed [CB-1:0] ax, ay, bx, by;
    logic                 closes;
    assign {rtype, ax, ay, bx, by, closes} = req.data;

    spct_pkg::state_t state_reg, state_next;
    logic [VW-1:0] vcnt_reg, vcnt_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic          ovf_reg, ovf_next;
    logic [VW-1:0] rd_reg, rd_next;
    logic signed [CB-1:0] qax_reg, qay_reg, qbx_reg, qby_reg;
    logic          acc;
    logic          drained;

    assign req.ready = (state_reg == spct_pkg::ST_IDLE) && !rsp.valid;
    assign acc = req.valid && req.ready;

    logic          we;
    logic [RW-1:0] rdata;
    logic          rvld_reg, rfirst_reg;

    spct_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(vcnt_reg[AW-1:0]),
        .wdata({ax, ay, closes}),
        .raddr(rd_reg[AW-1:0]),
        .rdata(rdata)
    );

    logic full;
    assign full = (vcnt_reg == VW'(MAX_VERTICES)) || (pcnt_reg == PW'(MAX_POLYGONS));
    assign we = acc && rtype == spct_pkg::REQ_APPEND && !full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spct_pkg::ST_IDLE:
            begin
                if (acc && rtype == spct_pkg::REQ_QUERY)
                begin
                    state_next = (vcnt_reg == '0) ? spct_pkg::ST_DRAIN : spct_pkg::ST_READ;
                end
            end
            spct_pkg::ST_READ:
            begin
                if (rd_reg == vcnt_reg - VW'(1))
                begin
                    state_next = spct_pkg::ST_DRAIN;
                end
            end
            spct_pkg::ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = spct_pkg::ST_OUT;
                end
            end
            spct_pkg::ST_OUT:
            begin
                state_next = spct_pkg::ST_IDLE;
            end
            default: state_next = spct_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        vcnt_next = vcnt_reg;
        pcnt_next = pcnt_reg;
        ovf_next  = ovf_reg;
        rd_next   = rd_reg;
        if (acc && rtype == spct_pkg::REQ_CLEAR)
        begin
            vcnt_next = '0;
            pcnt_next = '0;
            ovf_next  = 1'b0;
        end
        if (acc && rtype == spct_pkg::REQ_APPEND)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                vcnt_next = vcnt_reg + VW'(1);
                pcnt_next = pcnt_reg + PW'(closes);
            end
        end
        if (acc)
        begin
            rd_next = '0;
        end
        else if (state_reg == spct_pkg::ST_READ)
        begin
            rd_next = rd_reg + VW'(1);
        end
    end

    // edge former: pairs consecutive vertices, adds closing edge
    logic signed [CB-1:0] prvx_reg, prvy_reg, stx_reg, sty_reg;
    logic                 pend_reg;
    logic signed [CB-1:0] vx, vy;
    logic                 vl;
    logic signed [CB-1:0] nsx, nsy;
    assign {vx, vy, vl} = rdata;

    // a vertex may issue edge C-D and, on last, also the closing edge D-start
    logic                 e0v, e1v;
    logic signed [CB-1:0] e0cx, e0cy, e0dx, e0dy, e1cx, e1cy;
    always_comb
    begin
        e0v     = rvld_reg && !rfirst_reg && pend_reg;
        e0cx    = prvx_reg;
        e0cy    = prvy_reg;
        e0dx    = vx;
        e0dy    = vy;
        e1v     = rvld_reg && vl;
        e1cx    = vx;
        e1cy    = vy;
    end

    // edge queue: at most two per cycle in, one per cycle out
    logic signed [CB-1:0] qcx_reg [2], qcy_reg [2], qdx_reg [2], qdy_reg [2];
    logic                 qlast_reg [2];
    logic [1:0]           qn_reg;
    logic                 iv;
    logic signed [CB-1:0] icx, icy, idx, idy;
    logic                 ilast;

    always_comb
    begin
        iv    = 1'b0;
        icx   = qcx_reg[0];
        icy   = qcy_reg[0];
        idx   = qdx_reg[0];
        idy   = qdy_reg[0];
        ilast = qlast_reg[0];
        if (qn_reg != 2'd0)
        begin
            iv = 1'b1;
        end
        else if (e0v)
        begin
            iv = 1'b1; icx = e0cx; icy = e0cy; idx = e0dx; idy = e0dy; ilast = 1'b0;
        end
        else if (e1v)
        begin
            iv = 1'b1; icx = e1cx; icy = e1cy; idx = nsx; idy = nsy; ilast = 1'b1;
        end
    end

    logic        rfs;
    assign rfs = rvld_reg && (rfirst_reg || !pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spct_pkg::ST_IDLE;
            vcnt_reg  <= '0;
            pcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            rd_reg    <= '0;
            rvld_reg  <= 1'b0;
            rfirst_reg <= 1'b0;
            pend_reg  <= 1'b0;
            qn_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vcnt_reg   <= vcnt_next;
            pcnt_reg   <= pcnt_next;
            ovf_reg    <= ovf_next;
            rd_reg     <= rd_next;
            rvld_reg   <= (state_reg == spct_pkg::ST_READ);
            rfirst_reg <= (state_reg == spct_pkg::ST_READ) && (rd_reg == '0);
            if (rvld_reg)
            begin
                pend_reg <= !vl;
            end
            else if (acc)
            begin
                pend_reg <= 1'b0;
            end
            qn_reg <= qn_reg + 2'(e0v) + 2'(e1v) - 2'(iv);
        end
    end

    always_comb
    begin
        nsx = (rfs) ? vx : stx_reg;
        nsy = (rfs) ? vy : sty_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            qax_reg <= ax;
            qay_reg <= ay;
            qbx_reg <= bx;
            qby_reg <= by;
        end
        if (rvld_reg)
        begin
            prvx_reg <= vx;
            prvy_reg <= vy;
        end
        stx_reg <= nsx;
        sty_reg <= nsy;
        // shift the queue and append new edges behind remaining ones
        begin
            logic [1:0] k;
            k = qn_reg - 2'(qn_reg != 2'd0 ? 1'b1 : 1'b0);
            if (qn_reg == 2'd2)
            begin
                qcx_reg[0] <= qcx_reg[1]; qcy_reg[0] <= qcy_reg[1];
                qdx_reg[0] <= qdx_reg[1]; qdy_reg[0] <= qdy_reg[1];
                qlast_reg[0] <= qlast_reg[1];
            end
            if (qn_reg == 2'd0 && e0v && e1v)
            begin
                qcx_reg[0] <= e1cx; qcy_reg[0] <= e1cy;
                qdx_reg[0] <= nsx;  qdy_reg[0] <= nsy;
                qlast_reg[0] <= 1'b1;
            end
            else if (qn_reg != 2'd0)
            begin
                if (e0v)
                begin
                    qcx_reg[k[0]] <= e0cx; qcy_reg[k[0]] <= e0cy;
                    qdx_reg[k[0]] <= e0dx; qdy_reg[k[0]] <= e0dy;
                    qlast_reg[k[0]] <= 1'b0;
                end
                if (e1v)
                begin
                    qcx_reg[k[0] ^ e0v] <= e1cx; qcy_reg[k[0] ^ e0v] <= e1cy;
                    qdx_reg[k[0] ^ e0v] <= nsx;  qdy_reg[k[0] ^ e0v] <= nsy;
                    qlast_reg[k[0] ^ e0v] <= 1'b1;
                end
            end
        end
    end

    // four cells: s1, s2 around A-B; s3, s4 around C-D
    logic signed [CB:0] pv [4], qyv [4], pyv [4], qxv [4];
    always_comb
    begin
        qxv[0] = (CB+1)'(icx) - (CB+1)'(qax_reg); qyv[0] = (CB+1)'(icy) - (CB+1)'(qay_reg);
        qxv[1] = (CB+1)'(idx) - (CB+1)'(qax_reg); qyv[1] = (CB+1)'(idy) - (CB+1)'(qay_reg);
        pv[2]  = (CB+1)'(idx) - (CB+1)'(icx); pyv[2] = (CB+1)'(idy) - (CB+1)'(icy);
        qxv[2] = (CB+1)'(qax_reg) - (CB+1)'(icx); qyv[2] = (CB+1)'(qay_reg) - (CB+1)'(icy);
        pv[3]  = pv[2]; pyv[3] = pyv[2];
        qxv[3] = (CB+1)'(qbx_reg) - (CB+1)'(icx); qyv[3] = (CB+1)'(qby_reg) - (CB+1)'(icy);
        pv[0]  = (CB+1)'(qbx_reg) - (CB+1)'(qax_reg);
        pyv[0] = (CB+1)'(qby_reg) - (CB+1)'(qay_reg);
        pv[1]  = pv[0];
        pyv[1] = pyv[0];
    end

    logic       cv [4];
    logic [1:0] cs [4];
    for (genvar g = 0; g < 4; g++)
    begin : g_cell
        spct_cell #(.CB(CB)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (iv),
            .in_px   (pv[g]),
            .in_qy   (qyv[g]),
            .in_py   (pyv[g]),
            .in_qx   (qxv[g]),
            .out_vld (cv[g]),
            .out_sign(cs[g])
        );
    end

    logic [1:0] l_reg;
    logic       hit_reg;
    logic [MB-1:0] mask_reg;
    logic       any_reg;
    logic [XW-1:0] pidx_reg;
    logic       hit;
    logic       out_v_reg;
    assign hit = spct_pkg::pair_passes(cs[0], cs[1]) && spct_pkg::pair_passes(cs[2], cs[3]);
    assign drained = !rvld_reg && qn_reg == 2'd0 && !iv && l_reg == 2'd0 && !cv[0]
                     && state_reg == spct_pkg::ST_DRAIN;

    logic [1:0] lpipe_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpipe_reg <= '0;
            l_reg     <= '0;
            hit_reg   <= 1'b0;
            any_reg   <= 1'b0;
            mask_reg  <= '0;
            pidx_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            lpipe_reg <= {lpipe_reg[0], iv && ilast};
            l_reg     <= {l_reg[0], iv};
            if (acc)
            begin
                hit_reg  <= 1'b0;
                any_reg  <= 1'b0;
                mask_reg <= '0;
                pidx_reg <= '0;
            end
            else if (cv[0])
            begin
                if (lpipe_reg[1])
                begin
                    hit_reg <= 1'b0;
                    if (hit || hit_reg)
                    begin
                        any_reg <= 1'b1;
                        if (pidx_reg < XW'(MB))
                        begin
                            mask_reg[pidx_reg[$clog2(MB)-1:0]] <= 1'b1;
                        end
                    end
                    pidx_reg <= pidx_reg + XW'(1);
                end
                else
                begin
                    hit_reg <= hit_reg || hit;
                end
            end
            if (state_reg == spct_pkg::ST_OUT)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid = out_v_reg;
    assign rsp.data  = {any_reg, mask_reg, ovf_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != spct_pkg::ST_IDLE) |-> !req.ready)
        else $error("accept while busy");
    a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= VW'(MAX_VERTICES))
        else $error("vertex count overrun");
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qn_reg <= 2'd2)
        else $error("edge queue overrun");
endmodule
